>>> src/hhmm_pkg.sv
// Shared types, address constants and the echo-region address mapping for the memory map.
`default_nettype none

package hhmm_pkg;

    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int BOOT_IDX_W = 8;
    localparam int CMD_W = 2;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [DATA_W-1:0] byte_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ      = 2'd0,
        CMD_WRITE     = 2'd1,
        CMD_BOOT_LOAD = 2'd2,
        CMD_NONE      = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DMA,
        ST_DONE
    } state_t;

    localparam addr_t ECHO_LOW     = 16'hE000;
    localparam addr_t ECHO_HIGH    = 16'hFDFF;
    localparam addr_t ECHO_OFFSET  = 16'h2000;
    localparam addr_t DMA_REG      = 16'hFF46;
    localparam addr_t BOOT_OFF_REG = 16'hFF50;
    localparam byte_t OAM_PAGE     = 8'hFE;
    localparam addr_t LAST_ADDR    = 16'hFFFF;
    localparam byte_t ERASED_HIGH  = 8'hFF;
    localparam byte_t ERASED_LOW   = 8'h00;

    // Fold the echo region back onto the work RAM it shadows.
    function automatic addr_t unmirror(input addr_t a);
        addr_t r;
        r = a;
        if (a >= ECHO_LOW && a <= ECHO_HIGH) begin
            r = a - ECHO_OFFSET;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/hhmm_main_mem.sv
// Main 64 KiB byte memory with one write port and one registered read port.
`default_nettype none

module hhmm_main_mem (
    input  wire logic           aclk,
    input  wire logic           we,
    input  wire hhmm_pkg::addr_t waddr,
    input  wire hhmm_pkg::byte_t wdata,
    input  wire logic           re,
    input  wire hhmm_pkg::addr_t raddr,
    output hhmm_pkg::byte_t     rdata
);
    import hhmm_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    byte_t mem [0:DEPTH-1];
    byte_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds between reads so a stalled result stays valid.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> src/hhmm_boot_rom.sv
// Boot ROM image store, loaded by the CPU side and read through a registered port.
`default_nettype none

module hhmm_boot_rom #(
    parameter int DEPTH = 256
) (
    input  wire logic  aclk,
    input  wire logic  we,
    input  wire logic [hhmm_pkg::BOOT_IDX_W-1:0] widx,
    input  wire hhmm_pkg::byte_t wdata,
    input  wire logic  re,
    input  wire logic [hhmm_pkg::BOOT_IDX_W-1:0] ridx,
    output hhmm_pkg::byte_t rdata
);
    import hhmm_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    byte_t rom [0:DEPTH-1];
    byte_t rdata_reg;
    logic  widx_ok;

    // Loads beyond the image size are dropped.
    assign widx_ok = ({1'b0, widx} < (BOOT_IDX_W+1)'(DEPTH));

    always_ff @(posedge aclk) begin
        if (we && widx_ok) begin
            rom[widx[IDX_W-1:0]] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= rom[ridx[IDX_W-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> src/handheld_memory_map_with_oam_dma.sv
// Top level of the handheld memory map: command decode, boot overlay, echo mapping and OAM DMA.
`default_nettype none

// Each input word is one CPU command: s_tuser carries the command code (read, write or
// boot ROM load) and s_tdata the address and write byte; exactly one result word leaves
// on m_tdata for every command, holding the byte read for a read and zero otherwise.
// After reset the block sweeps the 64 KiB main memory once, one byte per cycle, to set
// the lower half to zero and the upper half to 0xFF; during the sweep s_tready stays
// low. A read puts the address into the synchronous memory, then the data into the
// output register. A write to 0xFF46 starts the OAM DMA, which streams DMA_LENGTH
// bytes through the single read and single write port of the main memory, one read
// and one write per cycle overlapped. The output register lets the next command be
// accepted while a result word still waits.
module handheld_memory_map_with_oam_dma #(
    parameter int DMA_LENGTH = 160,
    parameter int BOOT_SIZE  = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // [15:0] address, [23:16] write_data
    input  wire logic [1:0]  s_tuser,  // [1:0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata   // [7:0] read_data
);
    import hhmm_pkg::*;

    localparam int CNT_W = $clog2(DMA_LENGTH + 1);

    state_t state_reg, state_next;

    addr_t             clr_addr_reg, clr_addr_next;
    logic              boot_mode_reg, boot_mode_next;
    logic              rd_boot_reg, rd_boot_next;
    byte_t             dma_hi_reg, dma_hi_next;
    logic [CNT_W-1:0]  dma_cnt_reg, dma_cnt_next;
    logic              pend_valid_reg, pend_valid_next;
    byte_t             pend_idx_reg, pend_idx_next;
    logic              m_tvalid_reg, m_tvalid_next;
    byte_t             m_tdata_reg, m_tdata_next;

    // Input word fields.
    logic  in_accept;
    cmd_t  in_cmd;
    addr_t in_addr;
    byte_t in_data;
    addr_t in_phys;
    logic  in_boot_hit;
    logic  in_is_dma;

    // DMA source side.
    addr_t dma_src;
    logic  dma_issue;
    logic  dma_src_boot;

    // Memory port controls.
    logic  mem_we, mem_re, boot_we, boot_re;
    addr_t mem_waddr, mem_raddr;
    byte_t mem_wdata;
    logic [BOOT_IDX_W-1:0] boot_ridx;
    byte_t main_q, boot_q, rd_q;

    logic  out_free;
    logic  out_load;
    byte_t out_value;

    assign in_accept = s_tvalid && s_tready;
    assign in_cmd    = cmd_t'(s_tuser);
    assign in_addr   = s_tdata[15:0];
    assign in_data   = s_tdata[23:16];
    assign in_phys   = unmirror(in_addr);
    assign in_is_dma = (in_phys == DMA_REG);

    // The boot ROM shadows the bottom of the map only while boot mode is on.
    assign in_boot_hit = boot_mode_reg && (in_addr < ADDR_W'(BOOT_SIZE));

    // DMA lengths stay below one page, so the count is the low byte of the source.
    assign dma_src      = {dma_hi_reg, BOOT_IDX_W'(dma_cnt_reg)};
    assign dma_issue    = (state_reg == ST_DMA) && (dma_cnt_reg != CNT_W'(DMA_LENGTH));
    assign dma_src_boot = boot_mode_reg && (dma_src < ADDR_W'(BOOT_SIZE));

    // Whichever store the last issued read targeted supplies the byte.
    assign rd_q = rd_boot_reg ? boot_q : main_q;

    assign out_free = !m_tvalid_reg || m_tready;

    hhmm_main_mem u_main_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (main_q)
    );

    hhmm_boot_rom #(
        .DEPTH (BOOT_SIZE)
    ) u_boot_rom (
        .aclk  (aclk),
        .we    (boot_we),
        .widx  (in_addr[BOOT_IDX_W-1:0]),
        .wdata (in_data),
        .re    (boot_re),
        .ridx  (boot_ridx),
        .rdata (boot_q)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    if (in_cmd == CMD_READ) begin
                        state_next = ST_READ;
                    end else if (in_cmd == CMD_WRITE && in_is_dma) begin
                        state_next = ST_DMA;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_READ, ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DMA: begin
                if (!dma_issue) begin
                    state_next = ST_DONE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Memory port and output controls.
    always_comb begin
        s_tready  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = ERASED_LOW;
        mem_re    = 1'b0;
        mem_raddr = in_phys;
        boot_we   = 1'b0;
        boot_re   = 1'b0;
        boot_ridx = in_addr[BOOT_IDX_W-1:0];
        out_load  = 1'b0;
        out_value = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = clr_addr_reg[ADDR_W-1] ? ERASED_HIGH : ERASED_LOW;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (in_accept) begin
                    case (in_cmd)
                        CMD_READ: begin
                            mem_re  = 1'b1;
                            boot_re = 1'b1;
                        end
                        CMD_WRITE: begin
                            mem_we    = !in_is_dma;
                            mem_waddr = in_phys;
                            mem_wdata = in_data;
                        end
                        CMD_BOOT_LOAD: begin
                            boot_we = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                out_load  = out_free;
                out_value = rd_q;
            end
            ST_DMA: begin
                // Read of byte i overlaps the write of byte i-1; the source never
                // meets the pending destination, even when it is the OAM page.
                mem_re    = dma_issue;
                boot_re   = dma_issue;
                mem_raddr = unmirror(dma_src);
                boot_ridx = dma_src[BOOT_IDX_W-1:0];
                mem_we    = pend_valid_reg;
                mem_waddr = {OAM_PAGE, pend_idx_reg};
                mem_wdata = rd_q;
            end
            ST_DONE: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    // Datapath register updates.
    always_comb begin
        clr_addr_next   = clr_addr_reg;
        boot_mode_next  = boot_mode_reg;
        rd_boot_next    = rd_boot_reg;
        dma_hi_next     = dma_hi_reg;
        dma_cnt_next    = dma_cnt_reg;
        pend_valid_next = dma_issue;
        pend_idx_next   = pend_idx_reg;
        m_tdata_next    = m_tdata_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;

        if (state_reg == ST_CLEAR) begin
            clr_addr_next = clr_addr_reg + 1'b1;
        end
        if (in_accept && in_cmd == CMD_READ) begin
            rd_boot_next = in_boot_hit;
        end
        if (in_accept && in_cmd == CMD_WRITE) begin
            if (in_phys == BOOT_OFF_REG) begin
                boot_mode_next = 1'b0;
            end
            if (in_is_dma) begin
                dma_hi_next  = in_data;
                dma_cnt_next = '0;
            end
        end
        if (dma_issue) begin
            rd_boot_next  = dma_src_boot;
            dma_cnt_next  = dma_cnt_reg + 1'b1;
            pend_idx_next = BOOT_IDX_W'(dma_cnt_reg);
        end
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = out_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            boot_mode_reg  <= 1'b1;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            boot_mode_reg  <= boot_mode_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_boot_reg  <= rd_boot_next;
        dma_hi_reg   <= dma_hi_next;
        dma_cnt_reg  <= dma_cnt_next;
        pend_idx_reg <= pend_idx_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Once the boot ROM is switched out it stays out until reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !boot_mode_reg |=> !boot_mode_reg)
        else $error("boot mode came back on without reset");

    // A result word is never loaded over one that is still stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result word overwritten while stalled");

    // No new command is taken while a DMA byte is still waiting to be written.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |-> !pend_valid_reg)
        else $error("command accepted during DMA");

    // Every DMA destination lies inside the OAM block.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (pend_idx_reg < BOOT_IDX_W'(DMA_LENGTH)))
        else $error("DMA write beyond the OAM block");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for the handheld memory map with its boot overlay, echo region and OAM DMA.

module tb_top;
    import hhmm_pkg::*;

    // Block sizes as the top level is built here.
    localparam int DMA_LEN    = 160;
    localparam int BOOT_BYTES = 256;

    // The clearing sweep after reset keeps s_tready low while it writes all of main memory, so
    // the watchdog must allow for the whole sweep before it calls a silent stretch a hang.
    localparam int WATCHDOG_LIMIT = 300000;

    // A DMA write keeps the block busy while it copies DMA_LENGTH bytes; the tail wait covers
    // that with margin.
    localparam int TAIL_CYCLES = 400;

    // Length of the one long receiver hold-off, and the result count that triggers it.
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_TRIGGER = 150;

    // One pending CPU command, or a marker that makes the sender wait for all results.
    typedef struct {
        bit    pause;
        cmd_t  cmd;
        addr_t addr;
        byte_t wdata;
    } access_t;

    // One expected result word, with the command that caused it for the mismatch line.
    typedef struct {
        cmd_t  cmd;
        addr_t addr;
        byte_t read_data;
    } read_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata  = '0;  // [15:0] address, [23:16] write_data
    logic [1:0]  s_tuser  = '0;  // [1:0] cmd
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [7:0]  m_tdata;        // [7:0] read_data

    always #4 aclk = ~aclk;

    handheld_memory_map_with_oam_dma #(
        .DMA_LENGTH(DMA_LEN),
        .BOOT_SIZE (BOOT_BYTES)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Shadow of the memory map, advanced once per accepted command word.
    byte_t mem_img [0:65535];
    byte_t boot_img [0:255];
    bit    boot_on;

    // Light bookkeeping on the stimulus side, so that the generator never reads a boot
    // ROM entry that was never loaded, either directly or through a DMA from page zero.
    bit    gen_boot_on;
    bit    gen_loaded [0:255];
    int    load_next;
    addr_t hot_pool [0:15];

    access_t      access_q[$];
    read_result_t expect_q[$];
    read_result_t got_exp;

    int err_count      = 0;
    int results_seen   = 0;
    int idle_cycles    = 0;
    bit in_taken       = 1'b0;

    // Sender and receiver pacing state.
    int tx_gap         = 0;
    int tx_burst       = 0;
    int rx_stall       = 0;
    int rx_burst       = 0;
    int rx_hold        = 0;
    bit long_hold_done = 1'b0;

    // Echo region 0xE000..0xFDFF folds down onto 0xC000..0xDDFF.
    function automatic addr_t fold_echo(input addr_t a);
        if (a >= ECHO_LOW && a <= ECHO_HIGH) begin
            return a - ECHO_OFFSET;
        end
        return a;
    endfunction

    // A CPU-side read: the boot ROM shadows the bottom page while boot mode is set.
    function automatic byte_t mmap_read(input addr_t a);
        if (boot_on && a < addr_t'(BOOT_BYTES)) begin
            return boot_img[a[7:0]];
        end
        return mem_img[fold_echo(a)];
    endfunction

    // Applies one command to the shadow and returns the byte the block must answer with.
    function automatic byte_t mmap_access(input cmd_t c, input addr_t a, input byte_t d);
        byte_t r;
        addr_t fa;
        addr_t src;
        int    i;
        r = ERASED_LOW;
        case (c)
            CMD_READ: begin
                r = mmap_read(a);
            end
            CMD_WRITE: begin
                fa = fold_echo(a);
                if (fa == DMA_REG) begin
                    // The DMA register itself is never stored; the copy goes byte by
                    // byte in rising order so overlapping source and target behave.
                    src = {d, 8'h00};
                    for (i = 0; i < DMA_LEN; i++) begin
                        mem_img[{OAM_PAGE, 8'h00} + addr_t'(i)] = mmap_read(src + addr_t'(i));
                    end
                end else begin
                    if (fa == BOOT_OFF_REG) begin
                        boot_on = 1'b0;
                    end
                    mem_img[fa] = d;
                end
            end
            CMD_BOOT_LOAD: begin
                boot_img[a[7:0]] = d;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Gap length for one side: mostly zero or short, now and then long, and every so
    // often a burst of items with no gap at all.
    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            burst = $urandom_range(20, 60);
        end
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        err_count++;
    endtask

    // Queues one command after steering it away from reads of unloaded boot ROM bytes.
    task automatic push_access(input cmd_t c, input addr_t a, input byte_t d);
        access_t it;
        bit      low_ready;
        int      k;
        case (c)
            CMD_READ: begin
                if (gen_boot_on && a < addr_t'(BOOT_BYTES) && !gen_loaded[a[7:0]]) begin
                    a[8] = 1'b1;
                end
            end
            CMD_WRITE: begin
                if (fold_echo(a) == DMA_REG && gen_boot_on && d == 8'h00) begin
                    low_ready = 1'b1;
                    for (k = 0; k < DMA_LEN; k++) begin
                        if (!gen_loaded[k]) begin
                            low_ready = 1'b0;
                        end
                    end
                    if (!low_ready) begin
                        d = byte_t'($urandom_range(1, 255));
                    end
                end
                if (fold_echo(a) == BOOT_OFF_REG) begin
                    gen_boot_on = 1'b0;
                end
            end
            CMD_BOOT_LOAD: begin
                gen_loaded[a[7:0]] = 1'b1;
            end
            default: begin
            end
        endcase
        it.pause = 1'b0;
        it.cmd   = c;
        it.addr  = a;
        it.wdata = d;
        access_q.push_back(it);
    endtask

    // The sender holds at this marker until every expected result has come back.
    task automatic push_pause();
        access_t it;
        it.pause = 1'b1;
        it.cmd   = CMD_NONE;
        it.addr  = '0;
        it.wdata = '0;
        access_q.push_back(it);
    endtask

    // Addresses weighted toward places where a later read can see an earlier write:
    // a small pool of hot addresses (reached through either echo alias), the OAM area
    // the DMA fills, the boot page, the echo edges, work RAM and plain random addresses.
    function automatic addr_t pick_addr();
        addr_t a;
        int    r;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            a = hot_pool[$urandom_range(0, 15)];
            if ($urandom_range(0, 1) == 1) begin
                if (a >= 16'hC000 && a <= 16'hDDFF) begin
                    a = a + ECHO_OFFSET;
                end else if (a >= ECHO_LOW && a <= ECHO_HIGH) begin
                    a = a - ECHO_OFFSET;
                end
            end
        end else if (r < 40) begin
            a = {OAM_PAGE, byte_t'($urandom_range(0, 8'hBF))};
        end else if (r < 50) begin
            a = addr_t'($urandom_range(0, 255));
        end else if (r < 65) begin
            a = addr_t'($urandom);
        end else if (r < 75) begin
            case ($urandom_range(0, 8))
                0: a = 16'hE000;
                1: a = 16'hDFFF;
                2: a = 16'hFDFF;
                3: a = 16'hFE00;
                4: a = 16'hC000;
                5: a = 16'hDDFF;
                6: a = 16'hDE00;
                7: a = 16'hE001;
                default: a = 16'hFDFE;
            endcase
        end else begin
            a = addr_t'($urandom_range(16'hC000, 16'hDFFF));
        end
        return a;
    endfunction

    // Source page for a DMA: the boot page, work RAM, its echo, OAM itself, the I/O page
    // or anything at all.
    function automatic byte_t pick_page();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return byte_t'($urandom_range(8'hC0, 8'hDF));
            2: return byte_t'($urandom_range(8'hE0, 8'hFD));
            3: return OAM_PAGE;
            4: return 8'hFF;
            default: return byte_t'($urandom);
        endcase
    endfunction

    // One random command. While boot mode lasts, about half the commands load the boot
    // ROM in rising index order so that the overlay fills up; boot mode is kept on by
    // steering plain writes off 0xFF50 during that phase.
    task automatic gen_random(input bit boot_phase);
        int    r;
        cmd_t  c;
        addr_t a;
        byte_t d;
        byte_t idx;
        r = $urandom_range(0, 99);
        d = byte_t'($urandom);
        a = pick_addr();
        if (boot_phase) begin
            if (r < 55) begin
                c = CMD_BOOT_LOAD;
                if (load_next < BOOT_BYTES) begin
                    idx = byte_t'(load_next);
                    load_next++;
                end else begin
                    idx = byte_t'($urandom);
                end
                a = {byte_t'($urandom), idx};
            end else if (r < 75) begin
                c = CMD_READ;
            end else if (r < 94) begin
                c = CMD_WRITE;
                if (fold_echo(a) == BOOT_OFF_REG) begin
                    a = BOOT_OFF_REG + 16'd1;
                end
            end else if (r < 97) begin
                c = CMD_WRITE;
                a = DMA_REG;
                d = pick_page();
            end else begin
                c = CMD_NONE;
                a = addr_t'($urandom);
            end
        end else begin
            if (r < 45) begin
                c = CMD_READ;
            end else if (r < 85) begin
                c = CMD_WRITE;
            end else if (r < 93) begin
                c = CMD_WRITE;
                a = DMA_REG;
                d = pick_page();
            end else if (r < 97) begin
                c = CMD_NONE;
                a = addr_t'($urandom);
            end else begin
                c = CMD_BOOT_LOAD;
                a = addr_t'($urandom);
            end
        end
        push_access(c, a, d);
    endtask

    // Monitor: both channels are sampled at the rising edge. The result is checked
    // against the oldest expectation before this edge's command adds its own, so a
    // spurious result can never pair up with a command accepted at the same edge.
    always @(posedge aclk) begin
        in_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expect_q.size() == 0) begin
                    report_mismatch($sformatf("result word 0x%02h with no command pending",
                                              m_tdata));
                end else begin
                    got_exp = expect_q.pop_front();
                    if (m_tdata !== got_exp.read_data) begin
                        report_mismatch($sformatf("read_data for %s at 0x%04h: got 0x%02h, want 0x%02h",
                                                  got_exp.cmd.name(), got_exp.addr, m_tdata,
                                                  got_exp.read_data));
                    end
                end
                results_seen <= results_seen + 1;
            end
            if (s_tvalid && s_tready) begin
                got_exp.cmd       = cmd_t'(s_tuser);
                got_exp.addr      = s_tdata[15:0];
                got_exp.read_data = mmap_access(cmd_t'(s_tuser), s_tdata[15:0], s_tdata[23:16]);
                expect_q.push_back(got_exp);
            end
        end
    end

    // Driver: at the falling edge it either keeps holding an unaccepted word, counts down
    // a gap, waits at a pause marker for the results to drain, or presents the next word.
    // s_tvalid gets at most one assignment per edge, so a back-to-back word keeps it high.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !in_taken)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (access_q.size() != 0 && !access_q[0].pause) begin
                s_tdata  <= {access_q[0].wdata, access_q[0].addr};
                s_tuser  <= access_q[0].cmd;
                s_tvalid <= 1'b1;
                access_q.delete(0);
                tx_gap = pick_gap(tx_burst);
            end else begin
                if (access_q.size() != 0 && expect_q.size() == 0) begin
                    access_q.delete(0);
                end
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off once a number of results have come,
    // during which the sender keeps offering words so the block backs up into s_tready.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if (!long_hold_done && results_seen >= HOLD_TRIGGER) begin
            rx_hold = LONG_HOLD - 1;
            long_hold_done = 1'b1;
            m_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_tready <= 1'b0;
        end else begin
            rx_stall = pick_gap(rx_burst);
            if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: counts edges at which neither channel moves a word.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("handheld_memory_map_with_oam_dma verification failed");
            $finish;
        end
    end

    initial begin
        int k;
        for (k = 0; k < 65536; k++) begin
            mem_img[k] = (k < 32768) ? ERASED_LOW : ERASED_HIGH;
        end
        for (k = 0; k < 256; k++) begin
            boot_img[k]   = 8'h00;
            gen_loaded[k] = 1'b0;
        end
        boot_on     = 1'b1;
        gen_boot_on = 1'b1;
        load_next   = 0;
        for (k = 0; k < 16; k++) begin
            if (k < 8) begin
                hot_pool[k] = addr_t'($urandom_range(16'hC000, 16'hDDFF));
            end else if (k < 11) begin
                hot_pool[k] = addr_t'($urandom_range(16'h0100, 16'h7FFF));
            end else if (k < 13) begin
                hot_pool[k] = addr_t'($urandom_range(16'h8000, 16'hBFFF));
            end else begin
                hot_pool[k] = addr_t'($urandom_range(16'hFF80, 16'hFFFE));
            end
        end

        // Directed part. Boot overlay: loads at both index extremes, one of them through
        // an address whose high byte is not zero, then reads through the overlay.
        push_access(CMD_BOOT_LOAD, 16'h0000, 8'hA5);
        push_access(CMD_BOOT_LOAD, 16'hFFFF, 8'hFF);
        push_access(CMD_BOOT_LOAD, 16'h3A7E, 8'h00);
        push_access(CMD_READ, 16'h0000, 8'h00);
        push_access(CMD_READ, 16'h00FF, 8'hFF);
        push_access(CMD_READ, 16'h007E, 8'h00);
        // Reset contents at the edges of both halves and just above the overlay.
        push_access(CMD_READ, 16'h0100, 8'h00);
        push_access(CMD_READ, 16'h7FFF, 8'h00);
        push_access(CMD_READ, 16'h8000, 8'h00);
        push_access(CMD_READ, 16'hFFFF, 8'h00);
        // Echo region in both directions, at both of its ends.
        push_access(CMD_WRITE, 16'hC123, 8'h5A);
        push_access(CMD_READ, 16'hE123, 8'h00);
        push_access(CMD_WRITE, 16'hFDFF, 8'h3C);
        push_access(CMD_READ, 16'hDDFF, 8'h00);
        push_access(CMD_WRITE, 16'hE000, 8'h81);
        push_access(CMD_READ, 16'hC000, 8'h00);
        // The unused command answers zero and changes nothing.
        push_access(CMD_NONE, 16'hC000, 8'h77);
        // A write below the cartridge boundary is stored: there is no bank switching.
        push_access(CMD_WRITE, 16'h0150, 8'h99);
        push_access(CMD_READ, 16'h0150, 8'h00);
        push_access(CMD_WRITE, 16'h0000, 8'h42);
        // DMA from work RAM, then from the echo alias and from the I/O page.
        push_access(CMD_WRITE, DMA_REG, 8'hC0);
        push_access(CMD_READ, 16'hFE00, 8'h00);
        push_access(CMD_READ, 16'hFE9F, 8'h00);
        push_access(CMD_READ, 16'hFEA0, 8'h00);
        push_access(CMD_READ, DMA_REG, 8'h00);
        push_access(CMD_WRITE, DMA_REG, 8'hE1);
        push_access(CMD_READ, 16'hFE23, 8'h00);
        push_access(CMD_WRITE, DMA_REG, 8'hFF);
        push_pause();

        // Random part with boot mode still on.
        repeat (330) gen_random(1'b1);

        // DMA out of the boot page while the overlay is live, then boot mode is switched
        // off and the bottom page shows main memory again.
        push_access(CMD_WRITE, DMA_REG, 8'h00);
        push_access(CMD_READ, 16'hFE00, 8'h00);
        push_access(CMD_READ, 16'hFE5A, 8'h00);
        push_access(CMD_READ, 16'hFE9F, 8'h00);
        push_access(CMD_WRITE, BOOT_OFF_REG, byte_t'($urandom));
        push_access(CMD_READ, 16'h0000, 8'h00);
        push_access(CMD_READ, 16'h00FF, 8'h00);
        push_access(CMD_READ, BOOT_OFF_REG, 8'h00);
        push_pause();

        // Random part with boot mode off.
        repeat (135) gen_random(1'b0);
        push_pause();
        repeat (135) gen_random(1'b0);

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (access_q.size() != 0 || s_tvalid || expect_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expect_q.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived", expect_q.size()));
        end

        if (err_count == 0) begin
            $display("handheld_memory_map_with_oam_dma verification clean");
        end else begin
            $display("handheld_memory_map_with_oam_dma verification failed");
        end
        $finish;
    end

endmodule
